FILE: src/crep_pkg.sv
// ----------------------------------------------------------------------------
// crep_pkg
// Shared types and constants of the cumulative radial energy profile unit.
// ----------------------------------------------------------------------------
package crep_pkg;

	localparam int RADIUS_W = 16;
	localparam int ENERGY_W = 20;
	localparam int SUM_W    = 32;
	localparam int INDEX_W  = 5;
	localparam int COUNT_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd3;

	typedef struct packed {
		logic [RADIUS_W-1:0] radius;
		logic [ENERGY_W-1:0] transverse_energy;
		logic                last_constituent;
	} item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] bin_index;
		logic [SUM_W-1:0]   bin_energy;
		logic               inside_cone;
		logic               last_bin;
	} result_t;

	typedef struct packed {
		logic add;
		logic clear;
	} store_cmd_t;

endpackage

FILE: src/cumulative_radial_energy_profile_unit.sv
// ----------------------------------------------------------------------------
// cumulative_radial_energy_profile_unit
// Cumulative radial energy profile of one jet, one constituent per command.
// ----------------------------------------------------------------------------
// Usage:
//   Present a constituent on item and raise start; it is taken on a clock
//   edge where busy is low. The constituent walks the bins from the
//   outermost inwards, one bin per cycle through a single saturating adder,
//   and stops at the first bin whose limit lies below its radius.
//   Here n = bins in use, taken as 1 when zero and capped at the store depth.
//   On a constituent marked last_constituent the walk is followed by an
//   emit phase: one result beat per bin, bin 0 first, each held for one
//   cycle with result_valid high; last_bin marks bin n-1. The receiver
//   cannot stall, so beats leave at one per cycle. Afterwards all sums are
//   zero and the cone flag is one. busy stays high until the final beat.
//   Configuration is written through cfg_we/cfg_index/cfg_data, only while
//   idle, which is up to the user: the block does not enforce it.
//   Reset restores the default registers, empties all sums and sets the
//   cone flag.
// ----------------------------------------------------------------------------
module cumulative_radial_energy_profile_unit #(
	parameter int MAX_BINS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  crep_pkg::item_t                    item,
	output logic                               result_valid,
	output crep_pkg::result_t                  result,
	input  logic                               cfg_we,
	input  logic [crep_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crep_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import crep_pkg::*;

	localparam int NB = (MAX_BINS > 32) ? 32 : MAX_BINS;
	localparam int IW = (NB > 1) ? $clog2(NB) : 1;
	localparam logic [COUNT_W-1:0] NB_C = COUNT_W'(NB);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT
	} state_t;

	state_t                     state_q;
	logic [RADIUS_W-1:0]        max_radius_q;
	logic [RADIUS_W-1:0]        radius_step_q;
	logic [COUNT_W-1:0]         bins_in_use_q;
	logic [RADIUS_W-1:0]        tolerance_q;

	logic [RADIUS_W-1:0]        r_q;
	logic [ENERGY_W-1:0]        e_q;
	logic                       last_q;
	logic [COUNT_W-1:0]         n_q;
	logic [COUNT_W-1:0]         k_q;
	logic signed [RADIUS_W+1:0] limit_q;
	logic                       cone_q;
	logic                       result_valid_q;
	result_t                    result_q;

	logic [COUNT_W-1:0]         n_eff;
	logic [COUNT_W-1:0]         walk_idx;
	logic                       hit;
	logic [2*RADIUS_W-1:0]      excess;
	logic [2*RADIUS_W-1:0]      allowed;
	logic                       over_tol;
	logic                       k_is_last;
	store_cmd_t                 cmd;
	logic [IW-1:0]              store_idx;
	logic [SUM_W-1:0]           rd_data;

	always_comb begin
		priority if (bins_in_use_q == '0) begin
			n_eff = COUNT_W'(1);
		end else if (bins_in_use_q > NB_C) begin
			n_eff = NB_C;
		end else begin
			n_eff = bins_in_use_q;
		end
	end

	assign walk_idx  = n_q - COUNT_W'(1) - k_q;
	assign k_is_last = (k_q == n_q - COUNT_W'(1));
	assign hit       = $signed({2'b00, r_q}) <= limit_q;
	assign excess    = {r_q - max_radius_q, {RADIUS_W{1'b0}}};
	assign allowed   = {{RADIUS_W{1'b0}}, tolerance_q} * {{RADIUS_W{1'b0}}, max_radius_q};
	assign over_tol  = excess > allowed;

	assign cmd.add   = (state_q == ST_WALK) && (hit || ((k_q == '0) && !over_tol));
	assign cmd.clear = (state_q == ST_EMIT) && k_is_last;
	assign store_idx = (state_q == ST_WALK) ? walk_idx[IW-1:0] : k_q[IW-1:0];

	crep_bin_store #(
		.DEPTH (NB)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.idx     (store_idx),
		.addend  (e_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_radius_q  <= 16'd4096;
			radius_step_q <= 16'd410;
			bins_in_use_q <= 6'd10;
			tolerance_q   <= 16'd655;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_RADIUS:  max_radius_q  <= cfg_data;
				CFG_RADIUS_STEP: radius_step_q <= cfg_data;
				CFG_BINS_IN_USE: bins_in_use_q <= cfg_data[COUNT_W-1:0];
				CFG_TOLERANCE:   tolerance_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start && !busy) begin
			r_q  <= item.radius;
			e_q  <= item.transverse_energy;
			n_q  <= n_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			last_q         <= 1'b0;
			k_q            <= '0;
			limit_q        <= '0;
			cone_q         <= 1'b1;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= (state_q == ST_EMIT);
			unique case (state_q)
				ST_IDLE: begin
					if (start && !busy) begin
						last_q  <= item.last_constituent;
						k_q     <= '0;
						limit_q <= $signed({2'b00, max_radius_q});
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (!hit && (k_q == '0) && over_tol) begin
						cone_q <= 1'b0;
					end
					if (hit && !k_is_last) begin
						k_q     <= k_q + COUNT_W'(1);
						limit_q <= limit_q - $signed({2'b00, radius_step_q});
					end else begin
						k_q     <= '0;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					result_q.bin_index   <= k_q[INDEX_W-1:0];
					result_q.bin_energy  <= rd_data;
					result_q.inside_cone <= cone_q;
					result_q.last_bin    <= k_is_last;
					if (k_is_last) begin
						cone_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + COUNT_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE) || result_valid_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_beat_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result beat outside a busy period");

	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_bin |=> !result_valid)
		else $error("beat follows the last bin");

	a_bins_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_bin |=> result_valid &&
		result.bin_index == $past(result.bin_index) + INDEX_W'(1))
		else $error("bin beats out of order");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");
`endif

endmodule

FILE: src/crep_bin_store.sv
// ----------------------------------------------------------------------------
// crep_bin_store
// Per-bin cumulative sums with a shared saturating adder and valid bits.
// ----------------------------------------------------------------------------
module crep_bin_store #(
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  crep_pkg::store_cmd_t                   cmd,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] idx,
	input  logic [crep_pkg::ENERGY_W-1:0]          addend,
	output logic [crep_pkg::SUM_W-1:0]             rd_data
);
	import crep_pkg::*;

	logic [SUM_W-1:0] sums_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [SUM_W:0]   wide_sum;
	logic [SUM_W-1:0] sat_sum;

	assign rd_data  = valid_q[idx] ? sums_q[idx] : '0;
	assign wide_sum = {1'b0, rd_data} + {{(SUM_W + 1 - ENERGY_W){1'b0}}, addend};
	assign sat_sum  = wide_sum[SUM_W] ? {SUM_W{1'b1}} : wide_sum[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
		end else if (cmd.add) begin
			valid_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			sums_q[idx] <= sat_sum;
		end
	end

endmodule
